// ===== rtl/tcw_pkg.sv =====
// Shared types, constants and codes for the text console writer.
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int IDX_W   = 11;
    localparam int CELL_W  = COLOR_W + CHAR_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // Attribute after reset, and the blank cell after reset or clear
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [CELL_W-1:0]  BLANK_RESET = {RESET_COLOR, CH_SPACE};

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_WRITE,
        ST_SCROLL,
        ST_RADDR,
        ST_RWAIT,
        ST_DONE
    } tcw_state_t;

endpackage

// ===== rtl/text_console_writer.sv =====
// Text console writer: cursor sequencer around a row-rotated cell store.
//
// Commands: drive operation, char_code and cell_index with start high; the
// transaction is taken at a clock edge where start is high and busy is low.
// Each command gives one result: done is high for exactly one cycle with
// cursor_position and cell_data, and the receiver cannot stall it.
// A printable character, or a backspace, into a row not yet in use since
// reset or clear first sweeps that row to blank; a scroll (wrap or newline
// on the bottom row) sweeps the new bottom row. Each sweep runs over the
// single memory port, one cell per cycle. Scrolling rotates the top-row
// pointer instead of copying, so only the new bottom row is swept. A read
// of a cell in a row in use waits for the registered memory read data.
// Reset and clear mark every row unused; an unused row reads as blank space
// in colour 0x07, so there is no clearing pass. The colour register takes a
// write on its own valid/ready channel while no command is in progress.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tcw_pkg::OP_W-1:0]    operation,
    input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
    output logic                        done,
    output logic [tcw_pkg::IDX_W-1:0]   cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]  cell_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0] cfg_text_color
);

    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int DIV_W  = ADDR_W + 1;
    localparam int CMP_W  = IDX_W + ADDR_W;

    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W:0]    ROWS_X   = (ROW_W + 1)'(ROWS);
    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
    localparam logic [DIV_W-1:0]  COLS_D   = DIV_W'(COLUMNS);
    localparam logic [CMP_W-1:0]  CELLS_C  = CMP_W'(CELLS);

    // Control state
    tcw_state_t         state_reg, state_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [ROWS-1:0]    valid_reg, valid_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [COL_W-1:0]   sweep_reg, sweep_next;
    logic               scroll_reg, scroll_next;

    // Payload state
    logic [OP_W-1:0]    op_reg, op_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ROW_W-1:0]   wr_row_reg, wr_row_next;
    logic [COL_W-1:0]   wr_col_reg, wr_col_next;
    logic [CELL_W-1:0]  wr_data_reg, wr_data_next;
    logic [ROW_W-1:0]   rd_row_reg, rd_row_next;
    logic [COL_W-1:0]   rd_col_reg, rd_col_next;
    logic [CELL_W-1:0]  data_reg, data_next;

    // Put decode
    logic               put_write;
    logic               put_scroll;
    logic [ROW_W-1:0]   put_tgt_row;
    logic [COL_W-1:0]   put_tgt_col;
    logic [CELL_W-1:0]  put_data;
    logic [ROW_W-1:0]   put_row;
    logic [COL_W-1:0]   put_col;
    logic [ROW_W-1:0]   put_phys;

    // Read decode
    logic               in_range;
    logic [ROW_W-1:0]   div_q;
    logic [COL_W-1:0]   div_r;
    logic [ROW_W-1:0]   rd_phys;

    // Memory port
    logic               mem_we;
    logic               mem_re;
    logic [ROW_W-1:0]   mem_row;
    logic [COL_W-1:0]   mem_col;
    logic [ADDR_W-1:0]  mem_addr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [CELL_W-1:0]  mem_rdata;

    logic               accept;
    logic [ADDR_W-1:0]  pos_full;

    // Map a screen row to its place in the rotated store
    function automatic logic [ROW_W-1:0] phys_row(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] row
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= ROWS_X)
        begin
            sum = sum - ROWS_X;
        end
        return sum[ROW_W-1:0];
    endfunction

    assign accept = start && !busy;

    // Decode a put: target cell, written value and new cursor
    always_comb
    begin
        put_write   = 1'b0;
        put_scroll  = 1'b0;
        put_tgt_row = cur_row_reg;
        put_tgt_col = cur_col_reg;
        put_data    = {color_reg, char_reg};
        put_row     = cur_row_reg;
        put_col     = cur_col_reg;
        if (char_reg == CH_NEWLINE)
        begin
            put_col = '0;
            if (cur_row_reg == LAST_ROW)
            begin
                put_scroll = 1'b1;
            end
            else
            begin
                put_row = cur_row_reg + 1'b1;
            end
        end
        else if (char_reg == CH_BACKSPACE)
        begin
            put_data = {color_reg, CH_SPACE};
            if (cur_col_reg != '0)
            begin
                put_write   = 1'b1;
                put_tgt_col = cur_col_reg - 1'b1;
                put_col     = cur_col_reg - 1'b1;
            end
            else if (cur_row_reg != '0)
            begin
                put_write   = 1'b1;
                put_tgt_row = cur_row_reg - 1'b1;
                put_tgt_col = LAST_COL;
                put_row     = cur_row_reg - 1'b1;
                put_col     = LAST_COL;
            end
        end
        else
        begin
            put_write = 1'b1;
            if (cur_col_reg == LAST_COL)
            begin
                put_col = '0;
                if (cur_row_reg == LAST_ROW)
                begin
                    put_scroll = 1'b1;
                end
                else
                begin
                    put_row = cur_row_reg + 1'b1;
                end
            end
            else
            begin
                put_col = cur_col_reg + 1'b1;
            end
        end
        put_phys = phys_row(top_reg, put_tgt_row);
    end

    // Split the linear read index into row and column, one quotient bit a step
    always_comb
    begin : row_split
        logic [DIV_W-1:0] rem;
        rem   = DIV_W'(idx_reg);
        div_q = '0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            if (rem >= (COLS_D << b))
            begin
                rem      = rem - (COLS_D << b);
                div_q[b] = 1'b1;
            end
        end
        div_r    = COL_W'(rem);
        in_range = CMP_W'(idx_reg) < CELLS_C;
    end

    assign rd_phys = phys_row(top_reg, rd_row_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        if (put_write)
                        begin
                            state_next = valid_reg[put_phys] ? ST_WRITE : ST_FILL;
                        end
                        else if (put_scroll)
                        begin
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_READ:
                    begin
                        state_next = in_range ? ST_RADDR : ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_FILL:
            begin
                if (sweep_reg == LAST_COL)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = scroll_reg ? ST_SCROLL : ST_DONE;
            end
            ST_SCROLL:
            begin
                if (sweep_reg == LAST_COL)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RADDR:
            begin
                state_next = valid_reg[rd_phys] ? ST_RWAIT : ST_DONE;
            end
            ST_RWAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory port control
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        top_next     = top_reg;
        valid_next   = valid_reg;
        color_next   = color_reg;
        sweep_next   = sweep_reg;
        scroll_next  = scroll_reg;
        op_next      = op_reg;
        char_next    = char_reg;
        idx_next     = idx_reg;
        wr_row_next  = wr_row_reg;
        wr_col_next  = wr_col_reg;
        wr_data_next = wr_data_reg;
        rd_row_next  = rd_row_reg;
        rd_col_next  = rd_col_reg;
        data_next    = data_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_row      = wr_row_reg;
        mem_col      = wr_col_reg;
        mem_wdata    = wr_data_reg;

        // Take a colour write
        if (cfg_valid && cfg_ready)
        begin
            color_next = cfg_text_color;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = operation;
                    char_next = char_code;
                    idx_next  = cell_index;
                end
            end
            ST_EXEC:
            begin
                data_next  = '0;
                sweep_next = '0;
                case (op_reg)
                    OP_PUT:
                    begin
                        cur_row_next = put_row;
                        cur_col_next = put_col;
                        scroll_next  = put_scroll;
                        wr_row_next  = put_phys;
                        wr_col_next  = put_tgt_col;
                        wr_data_next = put_data;
                    end
                    OP_CLEAR:
                    begin
                        valid_next   = '0;
                        top_next     = '0;
                        cur_row_next = '0;
                        cur_col_next = '0;
                    end
                    OP_READ:
                    begin
                        rd_row_next = div_q;
                        rd_col_next = div_r;
                    end
                    default:
                    begin
                        data_next = '0;
                    end
                endcase
            end
            ST_FILL:
            begin
                // Blank an unused row before its first write
                mem_we    = 1'b1;
                mem_col   = sweep_reg;
                mem_wdata = BLANK_RESET;
                if (sweep_reg == LAST_COL)
                begin
                    valid_next[wr_row_reg] = 1'b1;
                    sweep_next             = '0;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
            end
            ST_SCROLL:
            begin
                // Old top row becomes the new bottom row
                mem_we    = 1'b1;
                mem_row   = top_reg;
                mem_col   = sweep_reg;
                mem_wdata = {color_reg, CH_SPACE};
                if (sweep_reg == LAST_COL)
                begin
                    valid_next[top_reg] = 1'b1;
                    sweep_next          = '0;
                    top_next            = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_RADDR:
            begin
                mem_row = rd_phys;
                mem_col = rd_col_reg;
                if (valid_reg[rd_phys])
                begin
                    mem_re = 1'b1;
                end
                else
                begin
                    data_next = BLANK_RESET;
                end
            end
            ST_RWAIT:
            begin
                data_next = mem_rdata;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    assign mem_addr = mem_row * COLS_A + ADDR_W'(mem_col);

    // Handshake outputs
    always_comb
    begin
        busy      = state_reg != ST_IDLE;
        done      = state_reg == ST_DONE;
        cfg_ready = state_reg == ST_IDLE;
    end

    // Report cursor and read data
    assign pos_full        = cur_row_reg * COLS_A + ADDR_W'(cur_col_reg);
    assign cursor_position = IDX_W'(pos_full);
    assign cell_data       = data_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            top_reg     <= '0;
            valid_reg   <= '0;
            color_reg   <= RESET_COLOR;
            sweep_reg   <= '0;
            scroll_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            top_reg     <= top_next;
            valid_reg   <= valid_next;
            color_reg   <= color_next;
            sweep_reg   <= sweep_next;
            scroll_reg  <= scroll_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        char_reg    <= char_next;
        idx_reg     <= idx_next;
        wr_row_reg  <= wr_row_next;
        wr_col_reg  <= wr_col_next;
        wr_data_reg <= wr_data_next;
        rd_row_reg  <= rd_row_next;
        rd_col_reg  <= rd_col_next;
        data_reg    <= data_next;
    end

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

// ===== rtl/tcw_cell_ram.sv =====
// Single-port cell store with registered read data.
module tcw_cell_ram #(
    parameter int DEPTH  = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS,
    parameter int ADDR_W = $clog2(tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS),
    parameter int DATA_W = tcw_pkg::CELL_W
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write one cell
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Read one cell, data valid the next cycle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_ready
);

    // Result strobe only inside a command
    a_done_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a command");

    // Strobe lasts one cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // Accepted command raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

    // Colour register locked while a command runs
    a_cfg_locked: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
        else $error("colour write offered during a command");

    // Busy drops only after the result transaction
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("command ended without a result");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
);
